>>> rtl/core/assert_macros.svh
// assertion helpers, compiled out when NO_ASSERTIONS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define EP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define EP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define EP_ASSERT(label, prop)
`define EP_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/core/epool_pkg.sv
`timescale 1ns / 1ps

package epool_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int KIND_W   = 2;
  localparam int OBJ_W    = 32;
  localparam int TAG_W    = 16;
  localparam int IDXF_W   = 5;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int DIV_W    = 17;
  localparam int FRAC_W   = 16;

  // threshold at which two zero objectives count as too close
  localparam logic [DIV_W-1:0] HALF_DIV = DIV_W'(32768);

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OBJ_W-1:0]  objective;
    logic [TAG_W-1:0]  solution_tag;
    logic [IDXF_W-1:0] entry_index;
  } epool_in_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               best_valid;
    logic [OBJ_W-1:0]   best_objective;
    logic [TAG_W-1:0]   best_tag;
    logic               best_ever_valid;
    logic [OBJ_W-1:0]   best_ever_objective;
    logic [TAG_W-1:0]   best_ever_tag;
  } epool_out_t;

endpackage

>>> rtl/core/elite_pool_replace_worst.sv
`timescale 1ns / 1ps
// channel  | direction | handshake               | word
// in_      | input     | in_valid / in_stall     | epool_in_t  (kind, objective, tag, index)
// out_     | output    | out_valid / out_stall   | epool_out_t (ok, slot, count, best, record)
// cfg_     | input     | cfg_wr_en               | cfg_wr_data (threshold)
//
// one word at a time; a one-read, one-write array is walked one entry per cycle through a
// compare pipe. an add scans the pool for entries too close to it, decides, then scans for the
// pool minimum; a valid remove at index i shifts the entries above i down by one before that
// scan; a clear empties the pool, and any other word only runs the minimum scan.
// synchronous active-low reset empties the pool and clears the record and threshold.
// in_stall is high until the result is registered; a stalled result holds as the next word enters

`include "assert_macros.svh"

module elite_pool_replace_worst import epool_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  epool_in_t        in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output epool_out_t       out_word,
  input  logic             cfg_wr_en,
  input  logic [DIV_W-1:0] cfg_wr_data
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_DECIDE   = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_BEST     = 8'b0010_0000,
    S_RECORD   = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  localparam int CMP_W  = IDXF_W + CNT_W;
  localparam int SUM_W  = OBJ_W + 1;
  localparam int PROD_W = DIV_W + SUM_W;
  localparam int LHS_W  = SUM_W + FRAC_W;

  state_t state_r, state_nxt;

  logic [OBJ_W-1:0] mem_obj [MAX_ENTRIES];
  logic [TAG_W-1:0] mem_tag [MAX_ENTRIES];

  epool_in_t        op_r;
  logic [DIV_W-1:0] md_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] issue_r;
  logic [CNT_W-1:0] shj_r;

  logic             p1_vld_r, p2_vld_r, p3_vld_r;
  logic [IDX_W-1:0] p1_idx_r;
  logic [OBJ_W-1:0] rd_obj_r;
  logic [TAG_W-1:0] rd_tag_r;
  logic [SUM_W-1:0] s2_r, tw2_r;
  logic             zero2_r, zero3_r;
  logic [PROD_W-1:0] prod3_r;
  logic [LHS_W-1:0] lhs3_r;
  logic             reject_r;

  logic [OBJ_W-1:0] worst_obj_r;
  logic [IDX_W-1:0] worst_idx_r;
  logic [OBJ_W-1:0] best_obj_r;
  logic [TAG_W-1:0] best_tag_r;

  logic             ok_r;
  logic [IDX_W-1:0] slot_r;
  logic             rec_valid_r;
  logic [OBJ_W-1:0] rec_obj_r;
  logic [TAG_W-1:0] rec_tag_r;

  logic             out_valid_r;
  epool_out_t       out_r;

  logic             scanning, issue_en, scan_done, out_free, in_take;
  logic             room, add_ok, rm_ok_in, close3;
  logic [IDX_W-1:0] add_slot;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [OBJ_W-1:0] wr_obj;
  logic [TAG_W-1:0] wr_tag;
  logic [SUM_W-1:0] sum2, dbl2, tw2;
  logic [OBJ_W-1:0] diff2;

  assign scanning  = (state_r == S_CHECK) || (state_r == S_BEST);
  assign issue_en  = scanning && (issue_r < count_r);
  assign scan_done = scanning && !issue_en && !p1_vld_r && !p2_vld_r && !p3_vld_r;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign rm_ok_in = CMP_W'(in_word.entry_index) < CMP_W'(count_r);
  assign room     = count_r < CNT_W'(MAX_ENTRIES);
  assign add_ok   = !reject_r && (room || (op_r.objective < worst_obj_r));
  assign add_slot = room ? count_r[IDX_W-1:0] : worst_idx_r;

  // similarity front end: sum and clipped doubled distance
  always_comb begin
    sum2  = {1'b0, op_r.objective} + {1'b0, rd_obj_r};
    diff2 = (op_r.objective > rd_obj_r) ? (op_r.objective - rd_obj_r)
                                        : (rd_obj_r - op_r.objective);
    dbl2  = {diff2, 1'b0};
    tw2   = (dbl2 > sum2) ? sum2 : dbl2;
  end

  // min(2d, s) * 2^16 < min_div * s, or the fixed half when s is zero
  assign close3 = zero3_r ? (md_r > HALF_DIV) : ({1'b0, lhs3_r} < prod3_r);

  assign rd_addr = (state_r == S_SHIFT_RD) ? shj_r[IDX_W-1:0] : issue_r[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = add_slot;
    wr_obj  = op_r.objective;
    wr_tag  = op_r.solution_tag;
    if (state_r == S_DECIDE) begin
      wr_en = add_ok && (op_r.kind == KIND_ADD);
    end else if (state_r == S_SHIFT_WR) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(shj_r - CNT_W'(1));
      wr_obj  = rd_obj_r;
      wr_tag  = rd_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_obj[wr_addr] <= wr_obj;
      mem_tag[wr_addr] <= wr_tag;
    end
    rd_obj_r <= mem_obj[rd_addr];
    rd_tag_r <= mem_tag[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_word.kind)
            KIND_ADD:    state_nxt = S_CHECK;
            KIND_REMOVE: state_nxt = rm_ok_in ? S_SHIFT_RD : S_BEST;
            default:     state_nxt = S_BEST;
          endcase
        end
      end
      S_CHECK:    if (scan_done) state_nxt = S_DECIDE;
      S_DECIDE:   state_nxt = S_BEST;
      S_SHIFT_RD: state_nxt = (shj_r < count_r) ? S_SHIFT_WR : S_BEST;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_BEST:     if (scan_done) state_nxt = S_RECORD;
      S_RECORD:   state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath stages and trackers, no reset needed
  always_ff @(posedge clk) begin
    p1_idx_r <= issue_r[IDX_W-1:0];
    s2_r     <= sum2;
    tw2_r    <= tw2;
    zero2_r  <= (sum2 == '0);
    prod3_r  <= PROD_W'(md_r) * PROD_W'(s2_r);
    lhs3_r   <= {tw2_r, {FRAC_W{1'b0}}};
    zero3_r  <= zero2_r;
    if (p1_vld_r) begin
      if ((p1_idx_r == '0) || (rd_obj_r > worst_obj_r)) begin
        worst_obj_r <= rd_obj_r;
        worst_idx_r <= p1_idx_r;
      end
      if ((p1_idx_r == '0) || (rd_obj_r < best_obj_r)) begin
        best_obj_r <= rd_obj_r;
        best_tag_r <= rd_tag_r;
      end
    end
    if (in_take) begin
      op_r <= in_word;
    end
    if (state_r == S_IDLE) begin
      shj_r <= CNT_W'(in_word.entry_index) + CNT_W'(1);
    end else if (state_r == S_SHIFT_WR) begin
      shj_r <= shj_r + CNT_W'(1);
    end
    if (state_r == S_OUT && out_free) begin
      out_r.ok                  <= ok_r;
      out_r.slot                <= SLOT_W'(slot_r);
      out_r.count               <= COUNT_W'(count_r);
      out_r.best_valid          <= (count_r != '0);
      out_r.best_objective      <= (count_r != '0) ? best_obj_r : '0;
      out_r.best_tag            <= (count_r != '0) ? best_tag_r : '0;
      out_r.best_ever_valid     <= rec_valid_r;
      out_r.best_ever_objective <= rec_obj_r;
      out_r.best_ever_tag       <= rec_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      md_r        <= '0;
      count_r     <= '0;
      issue_r     <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      reject_r    <= 1'b0;
      ok_r        <= 1'b0;
      slot_r      <= '0;
      rec_valid_r <= 1'b0;
      rec_obj_r   <= '0;
      rec_tag_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= issue_en;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      // scan counter only runs inside a scan
      issue_r  <= issue_en ? (issue_r + CNT_W'(1)) : (scanning ? issue_r : '0);

      if (cfg_wr_en) begin
        md_r <= cfg_wr_data;
      end

      if (state_r == S_CHECK && p3_vld_r && close3) begin
        reject_r <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ok_r     <= (in_word.kind == KIND_CLEAR);
            slot_r   <= '0;
            reject_r <= 1'b0;
            if (in_word.kind == KIND_CLEAR) begin
              count_r <= '0;
            end
          end
        end
        S_DECIDE: begin
          if (add_ok) begin
            ok_r   <= 1'b1;
            slot_r <= add_slot;
            if (room) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
        end
        S_SHIFT_RD: begin
          if (shj_r >= count_r) begin
            count_r <= count_r - CNT_W'(1);
            ok_r    <= 1'b1;
          end
        end
        S_RECORD: begin
          // record follows the pool minimum only after an accepted add
          if (ok_r && (op_r.kind == KIND_ADD) && (count_r != '0) &&
              (!rec_valid_r || (best_obj_r < rec_obj_r))) begin
            rec_valid_r <= 1'b1;
            rec_obj_r   <= best_obj_r;
            rec_tag_r   <= best_tag_r;
          end
        end
        default: ;
      endcase

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `EP_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_ENTRIES))
  `EP_ASSERT(a_pipe_in_scan, (p1_vld_r || p2_vld_r || p3_vld_r) |-> scanning)
  `EP_ASSERT(a_record_monotone, ($past(rst_n) && $past(rec_valid_r)) |->
    (rec_valid_r && (rec_obj_r <= $past(rec_obj_r))))
  `EP_ASSERT(a_best_valid_matches, out_valid_r |-> (out_r.best_valid == (out_r.count != '0)))

endmodule
